// ----- hdl/wtr_pkg.sv -----
`timescale 1ns / 1ps

package wtr_pkg;

    localparam int WAVE_BITS = 10;
    localparam int OUT_BITS  = 16;
    localparam int CFG_BITS  = 16;

    localparam int S_TDATA_W = ((WAVE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((3 * OUT_BITS + 7) / 8) * 8;

    localparam int WAVE_LO   = 350;
    localparam int WAVE_HI   = 780;
    localparam int ROM_DEPTH = WAVE_HI - WAVE_LO + 1;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    // A log table entry holds the channel-is-zero flag above -log2(x) in Q24.
    localparam int L_W       = 29;
    localparam int ENTRY_W   = L_W + 1;
    localparam int ROM_W     = ROM_DEPTH * ENTRY_W;

    localparam int FRAC_W    = 24;
    localparam int EXP_STEPS = FRAC_W;
    localparam int P_W       = 31;
    localparam int R_W       = 31;
    localparam int B_W       = 30;
    localparam int N_W       = P_W - FRAC_W;

    // Input register, table read, gamma product, one stage per exponent bit,
    // the integer shift and the final scale.
    localparam int ST_IN     = 0;
    localparam int ST_LOG    = 1;
    localparam int ST_POW    = 2;
    localparam int ST_EXP0   = 3;
    localparam int ST_SHIFT  = ST_EXP0 + EXP_STEPS;
    localparam int ST_SCALE  = ST_SHIFT + 1;
    localparam int N_STAGES  = ST_SCALE + 1;

    localparam int CH_RED    = 0;
    localparam int CH_GREEN  = 1;
    localparam int CH_BLUE   = 2;

    typedef enum logic {
        CFG_INTENSITY_MAX = 1'b0,
        CFG_GAMMA         = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [N_STAGES-1:0] en;
    } pipe_ctl_t;

    typedef logic [ENTRY_W-1:0] log_entry_t;

    // Shift-and-subtract division, used only while building constants.
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= b) begin
                r = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-(k+1)) in Q30, by repeated square roots.
    function automatic logic [B_W-1:0] exp_base(input int k);
        logic [63:0] b;
        b = 64'd1 << 29;
        for (int i = 0; i <= k; i++) begin
            b = isqrt64(b << 30);
        end
        return b[B_W-1:0];
    endfunction

    function automatic log_entry_t log_entry(input int w, input int ch);
        logic [63:0] cn, cd, fn, fd;
        logic [63:0] rn, rd, gn, gd, bn, bd;
        logic [63:0] num, den, x, m, frac, lv;
        int p;
        rn = 0; rd = 1; gn = 0; gd = 1; bn = 0; bd = 1;
        fn = 1; fd = 1;
        if (w <= 439) begin
            rn = 64'(440 - w); rd = 90; bn = 1;
        end else if (w <= 489) begin
            gn = 64'(w - 440); gd = 50; bn = 1;
        end else if (w <= 509) begin
            gn = 1; bn = 64'(510 - w); bd = 20;
        end else if (w <= 579) begin
            rn = 64'(w - 510); rd = 70; gn = 1;
        end else if (w <= 644) begin
            rn = 1; gn = 64'(645 - w); gd = 65;
        end else begin
            rn = 1;
        end
        if (w <= 419) begin
            fn = 64'(w - 320); fd = 100;
        end else if (w >= 701) begin
            fn = 64'(240 + 7 * (780 - w)); fd = 800;
        end
        if (ch == CH_RED) begin
            cn = rn; cd = rd;
        end else if (ch == CH_GREEN) begin
            cn = gn; cd = gd;
        end else begin
            cn = bn; cd = bd;
        end
        if (cn == 0) return {1'b1, {L_W{1'b0}}};
        num = cn * fn;
        den = cd * fd;
        x = udiv64((num << 31) + den, 2 * den);
        if (x == 0) x = 1;
        if (x > (64'd1 << 30)) x = 64'd1 << 30;
        p = 0;
        while (p < 30 && (x >> (p + 1)) != 0) p++;
        m = x << (30 - p);
        frac = 0;
        for (int i = 0; i < FRAC_W; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        lv = (64'(30 - p) << 24) - frac;
        return {1'b0, lv[L_W-1:0]};
    endfunction

    function automatic logic [ROM_W-1:0] build_rom(input int ch);
        logic [ROM_W-1:0] v;
        v = '0;
        for (int a = 0; a < ROM_DEPTH; a++) begin
            v[a*ENTRY_W +: ENTRY_W] = log_entry(WAVE_LO + a, ch);
        end
        return v;
    endfunction

endpackage

// ----- hdl/wtr_chan.sv -----
`timescale 1ns / 1ps

module wtr_chan (
    input  logic                          aclk,
    input  wtr_pkg::pipe_ctl_t            ctl,
    input  wtr_pkg::log_entry_t           entry,
    input  logic [wtr_pkg::CFG_BITS-1:0]  gamma_q2_14,
    input  logic [wtr_pkg::CFG_BITS-1:0]  intensity_max,
    output logic [wtr_pkg::OUT_BITS-1:0]  level
);
    import wtr_pkg::*;

    localparam int GP_W = L_W + CFG_BITS;
    localparam int SC_W = CFG_BITS + R_W + 1;

    logic [GP_W-1:0]     gprod;
    logic [P_W-1:0]      p_reg;
    logic [P_W-1:0]      p_next;
    logic [R_W-1:0]      r_reg  [EXP_STEPS];
    logic [P_W-1:0]      pk_reg [EXP_STEPS];
    logic [N_W-1:0]      n_int;
    logic [R_W-1:0]      sh_reg;
    logic [R_W-1:0]      sh_next;
    logic [SC_W-1:0]     scaled;
    logic [SC_W-31:0]    rounded;
    logic [SC_W-31:0]    cap;
    logic [OUT_BITS-1:0] level_reg;
    logic [OUT_BITS-1:0] level_next;

    // Power: P = round(L * gamma) in Q24. A zero channel is forced to a huge
    // exponent so that it decays to zero like any other underflow.
    always_comb begin
        gprod  = GP_W'(entry[L_W-1:0]) * GP_W'(gamma_q2_14) + GP_W'(8192);
        p_next = entry[L_W] ? {P_W{1'b1}} : gprod[14 +: P_W];
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[ST_POW]) begin
            p_reg <= p_next;
        end
    end

    // One stage per fraction bit of P, most significant bit first.
    for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
        localparam logic [B_W-1:0] BK = exp_base(k);
        logic [R_W-1:0]       r_in;
        logic [P_W-1:0]       p_in;
        logic [R_W+B_W-1:0]   mul;
        logic [R_W-1:0]       r_next;

        if (k == 0) begin : g_first
            assign r_in = R_W'(1) << 30;
            assign p_in = p_reg;
        end else begin : g_rest
            assign r_in = r_reg[k-1];
            assign p_in = pk_reg[k-1];
        end

        always_comb begin
            mul    = (R_W+B_W)'(r_in) * (R_W+B_W)'(BK);
            r_next = p_in[FRAC_W-1-k] ? mul[30 +: R_W] : r_in;
        end

        always_ff @(posedge aclk) begin
            if (ctl.en[ST_EXP0+k]) begin
                r_reg[k]  <= r_next;
                pk_reg[k] <= p_in;
            end
        end
    end

    always_comb begin
        n_int   = pk_reg[EXP_STEPS-1][FRAC_W +: N_W];
        sh_next = (n_int >= N_W'(31)) ? '0 : (r_reg[EXP_STEPS-1] >> n_int);
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[ST_SHIFT]) begin
            sh_reg <= sh_next;
        end
    end

    // Scale to full range with rounding, then clamp to the full-scale value.
    always_comb begin
        scaled  = SC_W'(intensity_max) * SC_W'(sh_reg) + (SC_W'(1) << 29);
        rounded = scaled[SC_W-1:30];
        cap     = (SC_W-30)'(intensity_max);
        if (cap > (SC_W-30)'((1 << OUT_BITS) - 1)) begin
            cap = (SC_W-30)'((1 << OUT_BITS) - 1);
        end
        level_next = (rounded > cap) ? OUT_BITS'(cap) : OUT_BITS'(rounded);
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[ST_SCALE]) begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

// ----- hdl/wavelength_to_rgb.sv -----
`timescale 1ns / 1ps
// The input transfer reaches m_tvalid through the 29 register stages.
// Throughput: one transfer per cycle when m_tready allows; stages move on their own so bubbles close up.
// Reset: synchronous, active-low aresetn clears all valid bits and loads
// intensity_max = 255 and gamma_q2_14 = 13107; the datapath registers are not reset.
// The log table is a constant ROM read in the second stage.

module wavelength_to_rgb (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wtr_pkg::S_TDATA_W-1:0]   s_tdata,  // [9:0] wavelength_nm, rest zero
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wtr_pkg::M_TDATA_W-1:0]   m_tdata,  // [15:0] red, [31:16] green, [47:32] blue
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_addr,
    input  logic [wtr_pkg::CFG_BITS-1:0]    cfg_data
);
    import wtr_pkg::*;

    localparam logic [ROM_W-1:0] ROM_RED   = build_rom(CH_RED);
    localparam logic [ROM_W-1:0] ROM_GREEN = build_rom(CH_GREEN);
    localparam logic [ROM_W-1:0] ROM_BLUE  = build_rom(CH_BLUE);

    logic [CFG_BITS-1:0]  imax_reg;
    logic [CFG_BITS-1:0]  gamma_reg;

    logic [N_STAGES-1:0]  v_reg;
    logic [N_STAGES-1:0]  v_next;
    pipe_ctl_t            ctl;

    logic [WAVE_BITS-1:0] w_reg;
    logic [WAVE_BITS-1:0] w_off;
    logic [ROM_AW-1:0]    addr;
    logic                 in_band;
    log_entry_t           ent_red_reg, ent_green_reg, ent_blue_reg;
    log_entry_t           ent_red_next, ent_green_next, ent_blue_next;

    logic [OUT_BITS-1:0]  red, green, blue;

    // Configuration: always ready; writes must be issued only while the pipe is empty (not enforced here).
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            imax_reg  <= CFG_BITS'(255);
            gamma_reg <= CFG_BITS'(13107);
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_addr))
                CFG_INTENSITY_MAX: imax_reg  <= cfg_data;
                CFG_GAMMA:         gamma_reg <= cfg_data;
                default:           imax_reg  <= imax_reg;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it loads too,
    // so a stall at the output only backs up as far as the first bubble.
    always_comb begin
        ctl.en[N_STAGES-1] = !v_reg[N_STAGES-1] || m_tready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            ctl.en[k] = !v_reg[k] || ctl.en[k+1];
        end
        v_next = v_reg;
        if (ctl.en[0]) begin
            v_next[0] = s_tvalid;
        end
        for (int k = 1; k < N_STAGES; k++) begin
            if (ctl.en[k]) begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_tready = ctl.en[ST_IN];

    always_ff @(posedge aclk) begin
        if (ctl.en[ST_IN]) begin
            w_reg <= s_tdata[WAVE_BITS-1:0];
        end
    end

    // Table read: -log2 of colour times fall-off for each channel. Outside the
    // visible range every channel is marked zero.
    always_comb begin
        in_band = (w_reg >= WAVE_BITS'(WAVE_LO)) && (w_reg <= WAVE_BITS'(WAVE_HI));
        w_off   = w_reg - WAVE_BITS'(WAVE_LO);
        addr    = in_band ? w_off[ROM_AW-1:0] : '0;
        ent_red_next   = ROM_RED[int'(addr)*ENTRY_W +: ENTRY_W];
        ent_green_next = ROM_GREEN[int'(addr)*ENTRY_W +: ENTRY_W];
        ent_blue_next  = ROM_BLUE[int'(addr)*ENTRY_W +: ENTRY_W];
        if (!in_band) begin
            ent_red_next[L_W]   = 1'b1;
            ent_green_next[L_W] = 1'b1;
            ent_blue_next[L_W]  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[ST_LOG]) begin
            ent_red_reg   <= ent_red_next;
            ent_green_reg <= ent_green_next;
            ent_blue_reg  <= ent_blue_next;
        end
    end

    // Gamma power and scaling, one datapath per channel.
    wtr_chan u_red (
        .aclk          (aclk),
        .ctl           (ctl),
        .entry         (ent_red_reg),
        .gamma_q2_14   (gamma_reg),
        .intensity_max (imax_reg),
        .level         (red)
    );

    wtr_chan u_green (
        .aclk          (aclk),
        .ctl           (ctl),
        .entry         (ent_green_reg),
        .gamma_q2_14   (gamma_reg),
        .intensity_max (imax_reg),
        .level         (green)
    );

    wtr_chan u_blue (
        .aclk          (aclk),
        .ctl           (ctl),
        .entry         (ent_blue_reg),
        .gamma_q2_14   (gamma_reg),
        .intensity_max (imax_reg),
        .level         (blue)
    );

    assign m_tvalid = v_reg[N_STAGES-1];
    assign m_tdata  = M_TDATA_W'({blue, green, red});

    // With the output stage empty, nothing can hold off the input.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled although the output stage is empty");

    // An input transfer always lands in the first stage.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v_reg[ST_IN])
        else $error("accepted transfer was not captured");

    // A held stage in the middle of the pipe keeps its item.
    a_mid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[ST_EXP0+12] && !ctl.en[ST_EXP0+12] |=> v_reg[ST_EXP0+12])
        else $error("stalled pipeline stage lost its item");

    // Reset empties the pipe.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && (v_reg == '0))
        else $error("valid bits survived reset");

endmodule
